// File: hdl/bb3_pkg.sv
// ---------------------------------------------------------------------------
// bb3_pkg: shared types and constants for the 3x3 box blur
// Register indexes, the stage command struct and the rounding-mean function.
// ---------------------------------------------------------------------------
package bb3_pkg;

	localparam int DefMaxWidth  = 1024;
	localparam int DefMaxHeight = 4096;

	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 13;
	localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'b0;
	localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;

	// one command per accepted item, controller to datapath
	typedef struct packed {
		logic       shift;     // advance window and row stores
		logic       emit;      // a result is produced by this item
		logic       use_left;  // left column inside frame
		logic       use_right; // right column inside frame
		logic       use_top;   // upper row inside frame
		logic       use_bot;   // lower row inside frame
		logic       last;      // final result of the frame
	} bb3_cmd_t;

	// rounded mean (2*sum+n)/(2n) for n in 1, 2, 3, 4, 6 or 9; sum <= 2295
	function automatic logic [7:0] bb3_mean(input logic [11:0] sum, input logic [3:0] n);
		logic [13:0] num;
		logic [31:0] prod;
		logic [7:0]  q;
		num = {sum, 1'b0} + 14'(n);
		q = 8'd0;
		unique case (n)
			4'd1: q = 8'(num >> 1);
			4'd2: q = 8'(num >> 2);
			4'd3: begin
				prod = 32'(num) * 32'd10923;
				q = 8'(prod >> 16);
			end
			4'd4: q = 8'(num >> 3);
			4'd6: begin
				prod = 32'(num) * 32'd10923;
				q = 8'(prod >> 17);
			end
			4'd9: begin
				prod = 32'(num) * 32'd58255;
				q = 8'(prod >> 20);
			end
			default: q = 8'(num >> 1);
		endcase
		return q;
	endfunction

endpackage

// File: hdl/bb3_stream_if.sv
// ---------------------------------------------------------------------------
// bb3_stream_if: valid/ready channel with a generic payload
// Used for the pixel input and the blurred pixel output.
// ---------------------------------------------------------------------------
interface bb3_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/box_blur_3x3_rgb.sv
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb: streaming 3x3 box blur of an 8-bit RGB raster
// Controller tracks frame position, datapath holds row stores and window.
// ---------------------------------------------------------------------------
// channel | dir | payload
// pix     | in  | mode, in_red, in_green, in_blue
// blur    | out | out_red, out_green, out_blue, frame_last
// cfg     | in  | cfg_we, cfg_index, cfg_data
// a result passes the row store read register, the window sum register, then
// rounding into the output register
// no new request is taken while an earlier one or a held result is still inside
// a new result that meets a stalled output moves to a hold register; input waits while it is full
// a drain request inside the frame is accepted on the channel and dropped.
// reset clears position and window; row stores need no clearing.
module box_blur_3x3_rgb import bb3_pkg::*; #(
	parameter int MaxWidth  = DefMaxWidth,
	parameter int MaxHeight = DefMaxHeight
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	bb3_stream_if.sink          pix,
	bb3_stream_if.source        blur
);
	logic busy, take, step;
	logic [$clog2(MaxWidth)-1:0] col;
	bb3_cmd_t cmd;
	logic [24:0] od;

	assign pix.ready = !busy && !cfg_we;
	assign step = pix.valid && pix.ready;

	bb3_ctrl #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_ctrl (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.step, .drain(pix.data.mode), .take, .col, .cmd
	);

	bb3_datapath #(.MaxWidth(MaxWidth)) u_dp (
		.clk, .arst_n, .take, .drain_pix(pix.data.mode), .col, .cmd,
		.pix({pix.data.in_red, pix.data.in_green, pix.data.in_blue}),
		.out_ready(blur.ready), .busy, .out_valid(blur.valid), .out_data(od)
	);

	assign blur.data.out_red    = od[24:17];
	assign blur.data.out_green  = od[16:9];
	assign blur.data.out_blue   = od[8:1];
	assign blur.data.frame_last = od[0];
endmodule

// File: hdl/bb3_ctrl.sv
// ---------------------------------------------------------------------------
// bb3_ctrl: frame position controller
// Tracks column, row and emitted position and issues one command per item.
// ---------------------------------------------------------------------------
module bb3_ctrl import bb3_pkg::*; #(
	parameter int MaxWidth  = DefMaxWidth,
	parameter int MaxHeight = DefMaxHeight
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CfgIdxW-1:0]           cfg_index,
	input  logic [CfgDataW-1:0]          cfg_data,
	input  logic                         step,
	input  logic                         drain,
	output logic                         take,
	output logic [$clog2(MaxWidth)-1:0]  col,
	output bb3_cmd_t                     cmd
);
	localparam int ColW = $clog2(MaxWidth);
	localparam int RowW = $clog2(MaxHeight + 1);
	localparam int WW   = $clog2(MaxWidth + 1);

	typedef enum logic [1:0] {ST_FILL, ST_RUN, ST_DRAIN} state_t;

	state_t state_q;
	logic [WW-1:0] w_q;
	logic [RowW-1:0] h_q;
	logic [ColW-1:0] col_q, ocol_q;
	logic [RowW-1:0] row_q, orow_q;
	logic [WW:0]     lead_q; // items taken before first emit

	logic in_frame, emit, last;
	logic [WW-1:0] wc;
	logic [RowW-1:0] hc;

	// clamped size of the value being written
	always_comb begin
		if (cfg_data[10:0] == 11'd0) wc = WW'(1);
		else if (32'(cfg_data[10:0]) > MaxWidth) wc = WW'(MaxWidth);
		else wc = WW'(cfg_data[10:0]);
		if (cfg_data == '0) hc = RowW'(1);
		else if (32'(cfg_data) > MaxHeight) hc = RowW'(MaxHeight);
		else hc = RowW'(cfg_data);
	end

	assign in_frame = (state_q != ST_DRAIN);
	assign take = step && !(in_frame && drain);
	assign emit = (lead_q == (WW+1)'(w_q) + 1'b1);
	assign last = emit && (WW'(ocol_q) + 1'b1 == w_q) && (orow_q + 1'b1 == h_q);
	assign col = col_q;

	always_comb begin
		cmd.shift     = take;
		cmd.emit      = take && emit;
		cmd.use_left  = ocol_q != '0;
		cmd.use_right = WW'(ocol_q) + 1'b1 < w_q;
		cmd.use_top   = orow_q != '0;
		cmd.use_bot   = orow_q + 1'b1 < h_q;
		cmd.last      = take && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_FILL;
			w_q      <= WW'((MaxWidth < 1024) ? MaxWidth : 1024);
			h_q      <= RowW'((MaxHeight < 768) ? MaxHeight : 768);
			col_q    <= '0;
			row_q    <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			lead_q   <= '0;
		end else if (cfg_we) begin
			if (cfg_index == RegFrameWidth) w_q <= wc;
			else h_q <= hc;
			state_q <= ST_FILL;
			col_q   <= '0;
			row_q   <= '0;
			ocol_q  <= '0;
			orow_q  <= '0;
			lead_q  <= '0;
		end else if (take) begin
			if (!emit) lead_q <= lead_q + 1'b1;
			if (last) begin
				state_q <= ST_FILL;
				col_q   <= '0;
				row_q   <= '0;
				ocol_q  <= '0;
				orow_q  <= '0;
				lead_q  <= '0;
			end else begin
				if (emit) begin
					if (WW'(ocol_q) + 1'b1 >= w_q) begin
						ocol_q <= '0;
						orow_q <= orow_q + 1'b1;
					end else ocol_q <= ocol_q + 1'b1;
				end
				if (in_frame) begin
					if (WW'(col_q) + 1'b1 >= w_q) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else col_q <= col_q + 1'b1;
					// end of the frame's pixels wins over the first emit
					if (WW'(col_q) + 1'b1 >= w_q && row_q + 1'b1 >= h_q)
						state_q <= ST_DRAIN;
					else if (state_q == ST_FILL && emit)
						state_q <= ST_RUN;
				end else begin
					if (WW'(col_q) + 1'b1 >= w_q) col_q <= '0;
					else col_q <= col_q + 1'b1;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.last |-> cmd.emit) else $error("last without emit");
	assert property (@(posedge clk) disable iff (!arst_n)
		take |-> WW'(col_q) < w_q) else $error("column out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd.last && !cfg_we) |=> (lead_q == '0)) else $error("no restart");
endmodule

// File: hdl/bb3_datapath.sv
// ---------------------------------------------------------------------------
// bb3_datapath: row stores, 3x3 window, sums and rounding
// Three-stage path: memory read, neighborhood sums, mean and output hold.
// ---------------------------------------------------------------------------
module bb3_datapath import bb3_pkg::*; #(
	parameter int MaxWidth = DefMaxWidth
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic                         drain_pix,
	input  logic [$clog2(MaxWidth)-1:0]  col,
	input  bb3_cmd_t                     cmd,
	input  logic [23:0]                  pix,
	input  logic                         out_ready,
	output logic                         busy,
	output logic                         out_valid,
	output logic [24:0]                  out_data
);
	localparam int ColW = $clog2(MaxWidth);

	logic [23:0] upper_mem [MaxWidth];
	logic [23:0] middle_mem [MaxWidth];
	logic [23:0] up_s1, mid_s1, new_s1;
	logic        v_s1, v_s2;
	bb3_cmd_t    cmd_s1, cmd_s2;
	logic [23:0] win_q [6];
	logic [11:0] sum_s2 [3];
	logic [3:0]  n_s2;
	logic [23:0] cv [3];
	logic [11:0] s [3];
	logic [3:0]  n;
	logic [24:0] mean_res;
	logic        hold_valid_q;
	logic [24:0] hold_data_q;

	// stage 1: read both row stores; write back with the new column
	always_ff @(posedge clk) begin
		if (take) begin
			up_s1  <= upper_mem[col];
			mid_s1 <= middle_mem[col];
			new_s1 <= drain_pix ? 24'd0 : pix;
			cmd_s1 <= cmd;
			upper_mem[col] <= middle_mem[col];
			middle_mem[col] <= drain_pix ? 24'd0 : pix;
		end
	end

	always_comb begin
		cv[0] = up_s1;
		cv[1] = mid_s1;
		cv[2] = new_s1;
		n = '0;
		for (int c = 0; c < 3; c++) s[c] = '0;
		for (int dc = 0; dc < 3; dc++) begin
			for (int dr = 0; dr < 3; dr++) begin
				logic [23:0] px;
				px = (dc == 2) ? cv[dr] : win_q[dc*3+dr];
				if ((dc != 0 || cmd_s1.use_left) && (dc != 2 || cmd_s1.use_right) &&
					(dr != 0 || cmd_s1.use_top) && (dr != 2 || cmd_s1.use_bot)) begin
					s[0] = s[0] + 12'(px[23:16]);
					s[1] = s[1] + 12'(px[15:8]);
					s[2] = s[2] + 12'(px[7:0]);
					n = n + 1'b1;
				end
			end
		end
	end

	assign mean_res = {bb3_mean(sum_s2[0], n_s2), bb3_mean(sum_s2[1], n_s2),
		bb3_mean(sum_s2[2], n_s2), cmd_s2.last};

	assign busy = v_s1 || v_s2 || hold_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
			hold_valid_q <= 1'b0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1 && cmd_s1.emit;
			if (v_s1) begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= cv[0];
				win_q[4] <= cv[1];
				win_q[5] <= cv[2];
			end
			if (!out_valid || out_ready) out_valid <= hold_valid_q || v_s2;
			// a new result meets a stalled output: park it
			if (v_s2 && out_valid && !out_ready) hold_valid_q <= 1'b1;
			else if (out_ready) hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			sum_s2 <= s;
			n_s2 <= n;
			cmd_s2 <= cmd_s1;
		end
		if (!out_valid || out_ready) begin
			if (hold_valid_q) out_data <= hold_data_q;
			else if (v_s2) out_data <= mean_res;
		end
		if (v_s2 && out_valid && !out_ready) hold_data_q <= mean_res;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !hold_valid_q) else $error("output overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !busy) else $error("item taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> n_s2 != 4'd0) else $error("empty neighborhood");
endmodule
